// File: design/dual_uart_scc_registers_core_defines.svh
`ifndef DUAL_UART_SCC_REGISTERS_CORE_DEFINES_SVH
`define DUAL_UART_SCC_REGISTERS_CORE_DEFINES_SVH

// clocked assertion with an explicit clock and active-low reset
`define DUSCC_ASSERT_CLK(clk, rst_n, label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion on the block clock and reset
`define DUSCC_ASSERT(label, prop, msg) \
    `DUSCC_ASSERT_CLK(i_clk, i_rst_n, label, prop, msg)

`endif

// File: design/duscc_pkg.sv
`default_nettype none

package duscc_pkg;

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  register_offset;
        logic [7:0]  write_data;
        logic [15:0] elapsed_ticks;
        logic [7:0]  received_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_char;
        logic       rx_dropped;
        logic       irq_pending;
    } t_out_item;

    typedef struct packed {
        logic send;
        logic tick;
        logic clr_flag;
    } t_tx_ctl;

    typedef struct packed {
        logic shifting;
        logic flag;
        logic flag_next;
    } t_tx_stat;

    typedef struct packed {
        logic push;
        logic pop;
    } t_rx_ctl;

    typedef struct packed {
        logic nonempty;
        logic full;
        logic nonempty_next;
    } t_rx_stat;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_RX    = 2'd3;

    localparam logic [7:0] CMD_MASK         = 8'h38;
    localparam logic [7:0] CMD_RESET_TX_INT = 8'h28;
    localparam logic [7:0] CMD_PTR_UPPER    = 8'h08;
    localparam logic [7:0] PTR_LOW_MASK     = 8'h07;

    localparam logic [3:0] PTR_WR0 = 4'd0;
    localparam logic [3:0] PTR_WR1 = 4'd1;
    localparam logic [3:0] PTR_RR3 = 4'd3;

    localparam logic [7:0] RR0_TXBUF_IDLE   = 8'h44;
    localparam logic [7:0] RR0_RXCHAR_READY = 8'h01;
    localparam logic [7:0] RR3_TX_A     = 8'h10;
    localparam logic [7:0] RR3_TX_B     = 8'h02;
    localparam logic [7:0] RR3_RX_A     = 8'h20;
    localparam logic [7:0] RR3_RX_B     = 8'h04;

    localparam logic [7:0] WR1_TX_INT_EN  = 8'h02;
    localparam logic [7:0] WR1_RX_INT_MSK = 8'h18;

    localparam logic [15:0] DRAIN_RESET = 16'd1024;

endpackage

`default_nettype wire

// File: design/duscc_rx_fifo.sv
`default_nettype none
`include "dual_uart_scc_registers_core_defines.svh"

module duscc_rx_fifo #(
    parameter int RX_DEPTH = 8
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  duscc_pkg::t_rx_ctl   i_ctl,
    input  wire  [7:0]           i_data,
    output duscc_pkg::t_rx_stat  o_stat,
    output logic [7:0]           o_head
);

    localparam int AW = $clog2(RX_DEPTH);
    localparam int FW = $clog2(RX_DEPTH + 1);

    logic [7:0]    r_mem [RX_DEPTH];
    logic [7:0]    r_head;
    logic [AW-1:0] r_rd;
    logic [AW-1:0] r_wr;
    logic [FW-1:0] r_fill;
    logic [AW-1:0] n_rd;
    logic [AW-1:0] n_wr;
    logic [FW-1:0] n_fill;
    logic          full;
    logic          nonempty;
    logic          do_push;
    logic          do_pop;

    assign full     = (r_fill == FW'(RX_DEPTH));
    assign nonempty = (r_fill != '0);
    assign do_push  = i_ctl.push && !full;
    assign do_pop   = i_ctl.pop && nonempty;

    always_comb begin
        n_rd   = r_rd;
        n_wr   = r_wr;
        n_fill = r_fill;
        if (do_pop) begin
            n_rd   = (r_rd == AW'(RX_DEPTH - 1)) ? '0 : r_rd + AW'(1);
            n_fill = r_fill - FW'(1);
        end
        if (do_push) begin
            n_wr   = (r_wr == AW'(RX_DEPTH - 1)) ? '0 : r_wr + AW'(1);
            n_fill = r_fill + FW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd   <= '0;
            r_wr   <= '0;
            r_fill <= '0;
        end else begin
            r_rd   <= n_rd;
            r_wr   <= n_wr;
            r_fill <= n_fill;
        end
    end

    // head register always mirrors the entry at the read pointer
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
        if (do_push && (r_wr == n_rd)) begin
            r_head <= i_data;
        end else begin
            r_head <= r_mem[n_rd];
        end
    end

    assign o_head              = r_head;
    assign o_stat.nonempty      = nonempty;
    assign o_stat.full          = full;
    assign o_stat.nonempty_next = (n_fill != '0);

    `DUSCC_ASSERT(a_fill_bound, (r_fill <= FW'(RX_DEPTH)), "rx fill above depth")
    `DUSCC_ASSERT(a_empty_ptrs, (r_fill == '0) |-> (r_rd == r_wr), "empty fifo with split pointers")
    `DUSCC_ASSERT(a_drop_holds, (i_ctl.push && full) |=> (r_fill == FW'(RX_DEPTH)), "push on full changed fill")

endmodule

`default_nettype wire

// File: design/duscc_tx_chan.sv
`default_nettype none
`include "dual_uart_scc_registers_core_defines.svh"

module duscc_tx_chan (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  duscc_pkg::t_tx_ctl   i_ctl,
    input  wire  [15:0]          i_elapsed,
    input  wire  [15:0]          i_drain,
    output duscc_pkg::t_tx_stat  o_stat
);

    logic        r_shifting;
    logic        r_flag;
    logic [15:0] r_rem;
    logic        n_shifting;
    logic        n_flag;
    logic [15:0] n_rem;

    always_comb begin
        n_shifting = r_shifting;
        n_flag     = r_flag;
        n_rem      = r_rem;
        priority if (i_ctl.send) begin
            n_shifting = 1'b1;
            n_flag     = 1'b0;
            n_rem      = i_drain;
        end else if (i_ctl.tick && r_shifting) begin
            // expiry drains the buffer and raises the tx flag
            if (i_elapsed >= r_rem) begin
                n_shifting = 1'b0;
                n_flag     = 1'b1;
                n_rem      = '0;
            end else begin
                n_rem = r_rem - i_elapsed;
            end
        end else if (i_ctl.clr_flag) begin
            n_flag = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shifting <= 1'b0;
            r_flag     <= 1'b0;
            r_rem      <= '0;
        end else begin
            r_shifting <= n_shifting;
            r_flag     <= n_flag;
            r_rem      <= n_rem;
        end
    end

    assign o_stat.shifting  = r_shifting;
    assign o_stat.flag      = r_flag;
    assign o_stat.flag_next = n_flag;

    `DUSCC_ASSERT(a_idle_zero, !r_shifting |-> (r_rem == '0), "idle channel with count left")
    `DUSCC_ASSERT(a_send_busy, i_ctl.send |=> (r_shifting && !r_flag), "send did not start channel")

endmodule

`default_nettype wire

// File: design/dual_uart_scc_registers_core.sv
`default_nettype none

// Two-channel serial controller register block with a shared receive fifo.
// One word (read, write, tick or received byte) is taken per clock while the
// input is not stalled, and each gives exactly one result word: it is held
// in the input register, where all register, fifo and transmit-timer updates
// are made, and then in the result register. Sustained rate is one word per
// cycle while the output is not stalled.
// The drain-time register is written through the config port while no word
// is held in the input register. The fifo needs no clearing pass after reset.

module dual_uart_scc_registers_core #(
    parameter int RX_DEPTH = 8
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  duscc_pkg::t_in_item   i_in_item,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output duscc_pkg::t_out_item  o_out_item,
    input  wire                   i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire  [15:0]           i_cfg_data
);

    logic                 r_in_valid;
    duscc_pkg::t_in_item  r_in;
    logic                 r_out_valid;
    duscc_pkg::t_out_item r_out;
    logic [15:0]          r_drain;
    logic [3:0]           r_ptr [2];
    logic [7:0]           r_wr1 [2];
    logic [3:0]           n_ptr [2];
    logic [7:0]           n_wr1 [2];

    logic                 advance;
    logic                 ch;
    logic                 is_data;
    logic [3:0]           ptr;
    logic [7:0]           cmd;
    logic                 rx_en_next;
    duscc_pkg::t_out_item res;
    duscc_pkg::t_rx_ctl   rx_ctl;
    duscc_pkg::t_rx_stat  rx_stat;
    logic [7:0]           rx_head;
    duscc_pkg::t_tx_ctl   tx_ctl  [2];
    duscc_pkg::t_tx_stat  tx_stat [2];

    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign o_cfg_ready = !r_in_valid;

    assign ch      = r_in.register_offset[3];
    assign is_data = r_in.register_offset[2];
    assign ptr     = r_ptr[ch];
    assign cmd     = r_in.write_data & duscc_pkg::CMD_MASK;

    assign rx_en_next = ((n_wr1[0] | n_wr1[1]) & duscc_pkg::WR1_RX_INT_MSK) != 8'h00;

    always_comb begin
        res       = '0;
        n_ptr[0]  = r_ptr[0];
        n_ptr[1]  = r_ptr[1];
        n_wr1[0]  = r_wr1[0];
        n_wr1[1]  = r_wr1[1];
        rx_ctl    = '0;
        tx_ctl[0] = '0;
        tx_ctl[1] = '0;
        if (advance) begin
            unique case (r_in.operation)
                duscc_pkg::OP_READ: begin
                    if (is_data) begin
                        rx_ctl.pop = 1'b1;
                        res.read_data = rx_stat.nonempty ? rx_head : 8'h00;
                    end else begin
                        n_ptr[ch] = duscc_pkg::PTR_WR0;
                        if (ptr == duscc_pkg::PTR_RR3) begin
                            if (tx_stat[1].flag && (r_wr1[1] & duscc_pkg::WR1_TX_INT_EN) != 8'h00)
                                res.read_data = res.read_data | duscc_pkg::RR3_TX_A;
                            if (tx_stat[0].flag && (r_wr1[0] & duscc_pkg::WR1_TX_INT_EN) != 8'h00)
                                res.read_data = res.read_data | duscc_pkg::RR3_TX_B;
                            if (rx_stat.nonempty
                                && (r_wr1[1] & duscc_pkg::WR1_RX_INT_MSK) != 8'h00)
                                res.read_data = res.read_data | duscc_pkg::RR3_RX_A;
                            if (rx_stat.nonempty
                                && (r_wr1[0] & duscc_pkg::WR1_RX_INT_MSK) != 8'h00)
                                res.read_data = res.read_data | duscc_pkg::RR3_RX_B;
                        end else begin
                            if (!tx_stat[ch].shifting)
                                res.read_data = duscc_pkg::RR0_TXBUF_IDLE;
                            if (rx_stat.nonempty)
                                res.read_data = res.read_data | duscc_pkg::RR0_RXCHAR_READY;
                        end
                    end
                end
                duscc_pkg::OP_WRITE: begin
                    if (is_data) begin
                        tx_ctl[ch].send = 1'b1;
                        res.tx_valid    = 1'b1;
                        res.tx_char     = r_in.write_data;
                    end else if (ptr == duscc_pkg::PTR_WR0) begin
                        tx_ctl[ch].clr_flag = (cmd == duscc_pkg::CMD_RESET_TX_INT);
                        // low pointer bits, plus the point-high command
                        n_ptr[ch] = {cmd == duscc_pkg::CMD_PTR_UPPER,
                                     r_in.write_data[2:0] & duscc_pkg::PTR_LOW_MASK[2:0]};
                    end else begin
                        if (ptr == duscc_pkg::PTR_WR1)
                            n_wr1[ch] = r_in.write_data;
                        n_ptr[ch] = duscc_pkg::PTR_WR0;
                    end
                end
                duscc_pkg::OP_TICK: begin
                    tx_ctl[0].tick = 1'b1;
                    tx_ctl[1].tick = 1'b1;
                end
                duscc_pkg::OP_RX: begin
                    rx_ctl.push    = 1'b1;
                    res.rx_dropped = rx_stat.full;
                end
                default: begin
                    res = '0;
                end
            endcase
        end
        // interrupt line as it stands once this word is applied
        res.irq_pending = (rx_stat.nonempty_next && rx_en_next)
            || (tx_stat[0].flag_next && (n_wr1[0] & duscc_pkg::WR1_TX_INT_EN) != 8'h00)
            || (tx_stat[1].flag_next && (n_wr1[1] & duscc_pkg::WR1_TX_INT_EN) != 8'h00);
    end

    duscc_rx_fifo #(
        .RX_DEPTH(RX_DEPTH)
    ) u_rx_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (rx_ctl),
        .i_data  (r_in.received_byte),
        .o_stat  (rx_stat),
        .o_head  (rx_head)
    );

    duscc_tx_chan u_tx_b (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (tx_ctl[0]),
        .i_elapsed (r_in.elapsed_ticks),
        .i_drain   (r_drain),
        .o_stat    (tx_stat[0])
    );

    duscc_tx_chan u_tx_a (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (tx_ctl[1]),
        .i_elapsed (r_in.elapsed_ticks),
        .i_drain   (r_drain),
        .o_stat    (tx_stat[1])
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_drain     <= duscc_pkg::DRAIN_RESET;
            r_ptr[0]    <= '0;
            r_ptr[1]    <= '0;
            r_wr1[0]    <= '0;
            r_wr1[1]    <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_drain <= i_cfg_data;
            end
            r_ptr[0] <= n_ptr[0];
            r_ptr[1] <= n_ptr[1];
            r_wr1[0] <= n_wr1[0];
            r_wr1[1] <= n_wr1[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_item;
        end
        if (advance) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire
